FILE: hw/rtl/sawa_pkg.sv
// shared types and codes for the stop-and-wait link controller
package sawa_pkg;

  localparam int SeqW   = 3;
  localparam int CountW = 16;
  localparam int CfgW   = 16;

  // request ops
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // received frame kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_NACK  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // result actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_DELIVER = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_RESEND  = 3'd4;
  localparam logic [2:0] ACT_RETRY   = 3'd5;
  localparam logic [2:0] ACT_SUCCESS = 3'd6;

  // configuration register indexes
  localparam logic CFG_RETRANSMIT = 1'b0;
  localparam logic CFG_RETRY_WAIT = 1'b1;

  localparam logic [CfgW-1:0] CFG_RESET = 16'd1000;

  // result queue
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef struct packed {
    logic [2:0]        action;
    logic [SeqW-1:0]   seq;
    logic [CfgW-1:0]   wait_value;
    logic              last;
  } sawa_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    sawa_res_t  res0;
    sawa_res_t  res1;
  } sawa_push_t;

  typedef struct packed {
    logic busy;
  } sawa_sts_t;

endpackage

FILE: hw/rtl/sawa_core.sv
// link state, configuration registers and per-request decision logic
module sawa_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sawa_pkg::CfgW-1:0]     cfg_wdata,
  input  logic                          take,
  input  logic [1:0]                    op,
  input  logic [1:0]                    frame_kind,
  input  logic [sawa_pkg::SeqW-1:0]     frame_seq,
  input  logic                          has_payload,
  input  logic                          frame_error,
  output sawa_pkg::sawa_push_t          push,
  output sawa_pkg::sawa_sts_t           sts
);
  import sawa_pkg::*;

  logic [CfgW-1:0]   rt_r, wait_r;
  logic [SeqW-1:0]   exp_r, exp_nxt;
  logic [SeqW-1:0]   tx_r, tx_nxt;
  logic              busy_r, busy_nxt;
  logic [CountW-1:0] ticks_r, ticks_nxt;

  logic [SeqW-1:0]   prev_seq;
  logic              data_ok;
  logic              ack_ok;
  logic [CountW:0]   tick_inc;

  assign prev_seq = exp_r - SeqW'(1);
  assign data_ok  = has_payload && !frame_error &&
                    ((frame_seq == exp_r) || (frame_seq == prev_seq));
  assign ack_ok   = !has_payload &&
                    ((frame_kind == KIND_ACK) || (frame_kind == KIND_NACK)) &&
                    (frame_seq == tx_r);
  assign tick_inc = {1'b0, ticks_r} + (CountW+1)'(1);

  always_comb begin
    push      = '0;
    exp_nxt   = exp_r;
    tx_nxt    = tx_r;
    busy_nxt  = busy_r;
    ticks_nxt = ticks_r;
    unique case (op)
      OP_FRAME: begin
        if (data_ok) begin
          push.res0.action = ACT_ACK;
          push.res0.seq    = frame_seq;
          if (frame_seq == exp_r) begin
            push.cnt         = 2'd2;
            push.res1.action = ACT_DELIVER;
            push.res1.seq    = frame_seq;
            push.res1.last   = 1'b1;
            exp_nxt          = exp_r + SeqW'(1);
          end else begin
            push.cnt       = 2'd1;
            push.res0.last = 1'b1;
          end
        end else if (ack_ok) begin
          push.cnt         = 2'd1;
          push.res0.action = ACT_SUCCESS;
          push.res0.seq    = frame_seq;
          push.res0.last   = 1'b1;
          tx_nxt           = tx_r + SeqW'(1);
          busy_nxt         = 1'b0;
          ticks_nxt        = '0;
        end
      end
      OP_SEND: begin
        push.cnt       = 2'd1;
        push.res0.last = 1'b1;
        if (busy_r) begin
          push.res0.action     = ACT_RETRY;
          push.res0.wait_value = wait_r;
        end else begin
          push.res0.action = ACT_SEND;
          push.res0.seq    = tx_r;
          busy_nxt         = 1'b1;
          ticks_nxt        = '0;
        end
      end
      OP_TICK: begin
        if (busy_r) begin
          if (tick_inc > {1'b0, rt_r}) begin
            push.cnt         = 2'd1;
            push.res0.action = ACT_RESEND;
            push.res0.seq    = tx_r;
            push.res0.last   = 1'b1;
            ticks_nxt        = '0;
          end else begin
            ticks_nxt = tick_inc[CountW-1:0];
          end
        end
      end
      default: begin
        push = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r    <= CFG_RESET;
      wait_r  <= CFG_RESET;
      exp_r   <= '0;
      tx_r    <= '0;
      busy_r  <= 1'b0;
      ticks_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RETRANSMIT) begin
          rt_r <= cfg_wdata;
        end else begin
          wait_r <= cfg_wdata;
        end
      end
      if (take) begin
        exp_r   <= exp_nxt;
        tx_r    <= tx_nxt;
        busy_r  <= busy_nxt;
        ticks_r <= ticks_nxt;
      end
    end
  end

  assign sts.busy = busy_r;

endmodule

FILE: hw/rtl/sawa_out_queue.sv
// small result queue, takes up to two results a cycle and hands out one
module sawa_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  sawa_pkg::sawa_push_t   push,
  input  logic                   pop,
  output logic                   not_empty,
  output logic                   near_full,
  output sawa_pkg::sawa_res_t    head
);
  import sawa_pkg::*;

  sawa_res_t          mem [QDepth];
  logic [QPtrW-1:0]   wr_r, wr_nxt;
  logic [QPtrW-1:0]   rd_r, rd_nxt;
  logic [QCntW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         n_in;

  assign n_in      = take ? push.cnt : 2'd0;
  assign wr_nxt    = wr_r + QPtrW'(n_in);
  assign rd_nxt    = rd_r + QPtrW'(pop);
  assign cnt_nxt   = cnt_r + QCntW'(n_in) - QCntW'(pop);
  assign not_empty = (cnt_r != '0);
  // keep room for a two-result request
  assign near_full = (cnt_r > QCntW'(QDepth - 2));
  assign head      = mem[rd_r];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_r] <= push.res0;
    end
    if (n_in == 2'd2) begin
      mem[wr_r + QPtrW'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/stop_and_wait_arq.sv
// stop-and-wait link controller top level
// a request's results are written into the result queue when it is taken and leave it on out_valid in order
// throughput: one request per cycle while in_stall is low; a request that frames an
//   ack and a delivery puts two results in the queue, so a run of those can fill it
// in_stall rises when the queue holds more than two results
// reset: synchronous, clears sequence numbers, busy flag, tick count and the queue
module stop_and_wait_arq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sawa_pkg::CfgW-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [1:0]                 in_frame_kind,
  input  logic [sawa_pkg::SeqW-1:0]  in_frame_seq,
  input  logic                       in_has_payload,
  input  logic                       in_frame_error,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_action,
  output logic [sawa_pkg::SeqW-1:0]  out_seq,
  output logic [sawa_pkg::CfgW-1:0]  out_wait_value,
  output logic                       out_last
);
  import sawa_pkg::*;

  logic       take;
  logic       pop;
  logic       near_full;
  sawa_push_t push;
  sawa_sts_t  sts;
  sawa_res_t  head;

  assign take = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  sawa_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .take        (take),
    .op          (in_op),
    .frame_kind  (in_frame_kind),
    .frame_seq   (in_frame_seq),
    .has_payload (in_has_payload),
    .frame_error (in_frame_error),
    .push        (push),
    .sts         (sts)
  );

  sawa_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .push      (push),
    .pop       (pop),
    .not_empty (out_valid),
    .near_full (near_full),
    .head      (head)
  );

  assign in_stall       = near_full;
  assign out_action     = head.action;
  assign out_seq        = head.seq;
  assign out_wait_value = head.wait_value;
  assign out_last       = head.last;

  // an empty queue always has room
  a_empty_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

  // a granted send leaves the link busy
  a_send_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_op == OP_SEND) && !sts.busy) |=> sts.busy)
    else $error("send request did not set busy");

  // two results only ever come as ack then deliver
  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (push.cnt == 2'd2)) |->
      ((push.res0.action == ACT_ACK) && (push.res1.action == ACT_DELIVER) &&
       !push.res0.last && push.res1.last && (push.res0.seq == push.res1.seq)))
    else $error("bad two-result request");

  // idle ticks never produce a result
  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_op == OP_TICK) && !sts.busy) |-> (push.cnt == 2'd0))
    else $error("tick while idle produced a result");

endmodule
